@@ rtl/skt_pkg.sv @@
// Shared codes, types and command/status structs for the sorted key table.
// Used by skt_ctrl, skt_dp and the sorted_key_table top level.
package skt_pkg;

  // Request type codes.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  // Width of the position and fill count result fields.
  localparam int unsigned PosWidth = 5;

  // Read address choice, relative to the slot index register.
  typedef enum logic [2:0] {
    RD_J,
    RD_J_P1,
    RD_J_P2,
    RD_J_M1,
    RD_J_M2
  } rd_sel_e;

  typedef struct packed {
    logic       load_req;    // latch the request beat, set the slot index
    logic       j_inc;
    logic       j_dec;
    logic       rd_en;
    rd_sel_e    rd_sel;
    logic       wr_en;       // write at the slot index
    logic       wr_new;      // write the request entry, else the read data
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_load;
    logic [1:0] res_status;
    logic       res_pos_en;  // position is slot index plus one, else 0
    logic       res_tag_en;  // found tag is the read tag, else 0
    logic       out_load;
  } skt_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       cnt_zero;
    logic       cnt_full;
    logic       greater;     // read key above request key (signed)
    logic       equal;       // read key equals request key
    logic       j_one;
    logic       j_next_last; // slot index plus one equals the count
    logic       shift_more;  // slot index plus two below the count
  } skt_stat_t;

endpackage

@@ rtl/skt_ctrl.sv @@
// Controller state machine of the sorted key table.
// Depends on skt_pkg; drives skt_dp through skt_cmd_t and reads skt_stat_t.
module skt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  skt_pkg::skt_stat_t stat_i,
  output skt_pkg::skt_cmd_t  cmd_o
);
  import skt_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_INS_CMP  = 3'd2;
  localparam logic [2:0] S_INS_PUT  = 3'd3;
  localparam logic [2:0] S_SR_CMP   = 3'd4;
  localparam logic [2:0] S_SHIFT    = 3'd5;
  localparam logic [2:0] S_WAIT_OUT = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.rd_sel   = RD_J;
    state_d        = state_q;
    cmd_o.load_req = in_valid_i && (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d        = S_WAIT_OUT;
        cmd_o.res_load = 1'b1;
        if (stat_i.req == REQ_INSERT) begin
          if (stat_i.cnt_full) begin
            cmd_o.res_status = ST_FULL;
          end else if (stat_i.cnt_zero) begin
            cmd_o.wr_en      = 1'b1;
            cmd_o.wr_new     = 1'b1;
            cmd_o.cnt_inc    = 1'b1;
            cmd_o.res_status = ST_OK;
            cmd_o.res_pos_en = 1'b1;
          end else begin
            cmd_o.res_load = 1'b0;
            cmd_o.rd_en    = 1'b1;
            cmd_o.rd_sel   = RD_J_M1;
            state_d        = S_INS_CMP;
          end
        end else if (stat_i.req == REQ_SEARCH || stat_i.req == REQ_REMOVE) begin
          if (stat_i.cnt_zero) begin
            cmd_o.res_status = ST_EMPTY;
          end else begin
            cmd_o.res_load = 1'b0;
            cmd_o.rd_en    = 1'b1;
            cmd_o.rd_sel   = RD_J;
            state_d        = S_SR_CMP;
          end
        end else begin
          cmd_o.res_status = ST_OK;
        end
      end
      S_INS_CMP: begin
        if (stat_i.greater) begin
          cmd_o.wr_en = 1'b1;
          cmd_o.j_dec = 1'b1;
          if (stat_i.j_one) begin
            state_d = S_INS_PUT;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_J_M2;
          end
        end else begin
          cmd_o.wr_en      = 1'b1;
          cmd_o.wr_new     = 1'b1;
          cmd_o.cnt_inc    = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_OK;
          cmd_o.res_pos_en = 1'b1;
          state_d          = S_WAIT_OUT;
        end
      end
      S_INS_PUT: begin
        cmd_o.wr_en      = 1'b1;
        cmd_o.wr_new     = 1'b1;
        cmd_o.cnt_inc    = 1'b1;
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = ST_OK;
        cmd_o.res_pos_en = 1'b1;
        state_d          = S_WAIT_OUT;
      end
      S_SR_CMP: begin
        if (stat_i.equal) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_OK;
          cmd_o.res_pos_en = 1'b1;
          cmd_o.res_tag_en = 1'b1;
          state_d          = S_WAIT_OUT;
          if (stat_i.req == REQ_REMOVE) begin
            if (stat_i.j_next_last) begin
              cmd_o.cnt_dec = 1'b1;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_J_P1;
              state_d      = S_SHIFT;
            end
          end
        end else if (stat_i.j_next_last) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_MISSING;
          state_d          = S_WAIT_OUT;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_J_P1;
          cmd_o.j_inc  = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.j_inc = 1'b1;
        if (stat_i.shift_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_J_P2;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_WAIT_OUT;
        end
      end
      S_WAIT_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/skt_dp.sv @@
// Datapath of the sorted key table: key and tag memories, slot index,
// entry count, compare logic and result registers. Depends on skt_pkg.
module skt_dp #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] key_i,
  input  logic [63:0]        tag_i,
  input  skt_pkg::skt_cmd_t  cmd_i,
  output skt_pkg::skt_stat_t stat_o,
  output logic [1:0]         status_o,
  output logic [skt_pkg::PosWidth-1:0] position_o,
  output logic [63:0]        found_tag_o,
  output logic [skt_pkg::PosWidth-1:0] fill_count_o
);
  import skt_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW = (CW + 1 > PosWidth) ? CW + 1 : PosWidth;

  logic signed [31:0] key_mem [TABLE_DEPTH];
  logic [63:0]        tag_mem [TABLE_DEPTH];

  logic [1:0]          req_q;
  logic signed [31:0]  key_q;
  logic [63:0]         tag_q;
  logic signed [31:0]  rd_key_q;
  logic [63:0]         rd_tag_q;
  logic [CW-1:0]       j_q, j_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [1:0]          res_status_q;
  logic [PosWidth-1:0] res_pos_q;
  logic [63:0]         res_tag_q;

  logic [CW:0]   j_w, cnt_w, ra_w;
  logic [XW-1:0] pos_w, fill_w;
  logic [AW-1:0] rd_addr, wr_addr;

  assign j_w   = {1'b0, j_q};
  assign cnt_w = {1'b0, cnt_q};

  always_comb begin
    case (cmd_i.rd_sel)
      RD_J:    ra_w = j_w;
      RD_J_P1: ra_w = j_w + (CW+1)'(1);
      RD_J_P2: ra_w = j_w + (CW+1)'(2);
      RD_J_M1: ra_w = j_w - (CW+1)'(1);
      RD_J_M2: ra_w = j_w - (CW+1)'(2);
      default: ra_w = j_w;
    endcase
  end

  assign rd_addr = ra_w[AW-1:0];
  assign wr_addr = j_w[AW-1:0];
  assign pos_w   = XW'(j_q) + XW'(1);
  assign fill_w  = XW'(cnt_q);

  assign stat_o.req         = req_q;
  assign stat_o.cnt_zero    = (cnt_q == '0);
  assign stat_o.cnt_full    = (cnt_q == CW'(TABLE_DEPTH));
  assign stat_o.greater     = (rd_key_q > key_q);
  assign stat_o.equal       = (rd_key_q == key_q);
  assign stat_o.j_one       = (j_q == CW'(1));
  assign stat_o.j_next_last = ((j_w + (CW+1)'(1)) == cnt_w);
  assign stat_o.shift_more  = ((j_w + (CW+1)'(2)) < cnt_w);

  always_comb begin
    j_d = j_q;
    if (cmd_i.load_req) begin
      j_d = (req_type_i == REQ_INSERT) ? cnt_q : '0;
    end else if (cmd_i.j_inc) begin
      j_d = j_q + CW'(1);
    end else if (cmd_i.j_dec) begin
      j_d = j_q - CW'(1);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q <= j_d;
    if (cmd_i.load_req) begin
      req_q <= req_type_i;
      key_q <= key_i;
      tag_q <= tag_i;
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_pos_q    <= cmd_i.res_pos_en ? pos_w[PosWidth-1:0] : '0;
      res_tag_q    <= cmd_i.res_tag_en ? rd_tag_q : '0;
    end
    if (cmd_i.out_load) begin
      status_o     <= res_status_q;
      position_o   <= res_pos_q;
      found_tag_o  <= res_tag_q;
      fill_count_o <= fill_w[PosWidth-1:0];
    end
  end

  // Table memories: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      key_mem[wr_addr] <= cmd_i.wr_new ? key_q : rd_key_q;
      tag_mem[wr_addr] <= cmd_i.wr_new ? tag_q : rd_tag_q;
    end
    if (cmd_i.rd_en) begin
      rd_key_q <= key_mem[rd_addr];
      rd_tag_q <= tag_mem[rd_addr];
    end
  end

endmodule

@@ rtl/sorted_key_table.sv @@
// Sorted key table: a table of signed keys with 64-bit tags held in ascending
// key order, taking insert, search and remove requests one at a time. Each
// request beat produces exactly one result beat carrying a status code, the
// 1-based slot (0 when there is none), the matched tag and the entry count
// after the request. Insert walks down from the top entry, moving each larger
// entry up one slot until it finds its place after any equal keys, and is
// refused with "table full" when every slot is taken. Search walks up from the
// bottom to the first matching key; remove does the same and then moves each
// later entry down one slot. Each step of a request reads one entry, as the
// key and tag memories have a single read port. The next request beat can be
// taken in the same cycle as the result is first offered. The input is ready
// only while no request is being worked on, but the result sits in an output
// register, so a new request beat is taken while the previous result beat
// still waits for the consumer. The memories need no clearing at reset: only
// slots below the entry count are ever read, and the count resets to 0.
// Depends on skt_pkg, skt_ctrl and skt_dp.
module sorted_key_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] key_i,
  input  logic [63:0]        tag_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [4:0]         position_o,
  output logic [63:0]        found_tag_o,
  output logic [4:0]         fill_count_o
);
  import skt_pkg::*;

  // Command and status bundles between the controller and the datapath.
  skt_cmd_t  cmd;
  skt_stat_t stat;

  // The controller sequences the scan and shift steps and owns both handshakes.
  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the table, the entry count and the result registers.
  skt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_type_i   (req_type_i),
    .key_i        (key_i),
    .tag_i        (tag_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .status_o     (status_o),
    .position_o   (position_o),
    .found_tag_o  (found_tag_o),
    .fill_count_o (fill_count_o)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for sorted_key_table: directed and random insert, search
// and remove requests, each result beat checked against a typed reply or the shadow table.
// Depends on skt_pkg and the sorted_key_table RTL.
module tb_top;
  import skt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned ITEM_TOTAL = 1850;
  // The slowest correct run, even with the longest sender gaps and receiver
  // stalls, stays well inside this limit, so it leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT = 900_000;
  localparam int unsigned REPORT_LIMIT = 10;

  // The package names the three real requests; the fourth code is a no-op.
  localparam logic [1:0] REQ_NOP = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  position;
    logic [63:0] found_tag;
    logic [4:0]  fill_count;
  } reply_t;

  // One row of directed stimulus. Rows marked typed carry a hand-written reply;
  // the others take the reply that the shadow table works out. A row may be sent
  // several times, with the tag counting up so that equal keys stay distinguishable.
  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] key;
    logic [63:0] tag;
    logic [4:0]  copies;
    logic        typed;
    reply_t      want;
  } stim_row_t;

  localparam int unsigned DIRECTED_ROWS = 15;
  localparam stim_row_t DIRECTED_STIM [DIRECTED_ROWS] = '{
    // Search and remove straight after reset find the table empty.
    '{REQ_SEARCH, 32'h0000_0000, 64'h0, 5'd1, 1'b1, '{ST_EMPTY, 5'd0, 64'h0, 5'd0}},
    '{REQ_REMOVE, 32'h7fff_ffff, 64'h0, 5'd1, 1'b1, '{ST_EMPTY, 5'd0, 64'h0, 5'd0}},
    // The spare request code does nothing, whatever its key and tag.
    '{REQ_NOP, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd1, 1'b1,
      '{ST_OK, 5'd0, 64'h0, 5'd0}},
    // Key extremes: the most negative key lands below zero, the largest on top.
    '{REQ_INSERT, 32'h0000_0000, 64'hffff_ffff_ffff_ffff, 5'd1, 1'b1,
      '{ST_OK, 5'd1, 64'h0, 5'd1}},
    '{REQ_INSERT, 32'h8000_0000, 64'h0, 5'd1, 1'b1, '{ST_OK, 5'd1, 64'h0, 5'd2}},
    '{REQ_INSERT, 32'h7fff_ffff, 64'h5555_5555_5555_5555, 5'd1, 1'b1,
      '{ST_OK, 5'd3, 64'h0, 5'd3}},
    // A second zero key has to go in after the first one.
    '{REQ_INSERT, 32'h0000_0000, 64'haaaa_aaaa_aaaa_aaaa, 5'd1, 1'b0, '0},
    '{REQ_SEARCH, 32'h0000_0000, 64'h0123_4567_89ab_cdef, 5'd1, 1'b0, '0},
    '{REQ_SEARCH, 32'h0000_0005, 64'h0, 5'd1, 1'b1, '{ST_MISSING, 5'd0, 64'h0, 5'd4}},
    '{REQ_REMOVE, 32'h7fff_ffff, 64'h0, 5'd1, 1'b0, '0},
    '{REQ_REMOVE, 32'h0000_0000, 64'h0, 5'd1, 1'b0, '0},
    '{REQ_REMOVE, 32'h0000_0001, 64'h0, 5'd1, 1'b1, '{ST_MISSING, 5'd0, 64'h0, 5'd2}},
    // Fill every remaining slot with one repeated key, then try once more.
    '{REQ_INSERT, 32'h0000_0010, 64'hf00d_0000_0000_0000, 5'd14, 1'b0, '0},
    '{REQ_INSERT, 32'h0000_0000, 64'h0, 5'd1, 1'b1, '{ST_FULL, 5'd0, 64'h0, 5'd16}},
    '{REQ_SEARCH, 32'h0000_0010, 64'h0, 5'd1, 1'b0, '0}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         req_type_i = REQ_INSERT;
  logic signed [31:0] key_i = '0;
  logic [63:0]        tag_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         status_o;
  logic [4:0]         position_o;
  logic [63:0]        found_tag_o;
  logic [4:0]         fill_count_o;

  // Shadow copy of the table contents, updated as each request beat is taken.
  logic signed [31:0] shadow_key [TABLE_DEPTH];
  logic [63:0]        shadow_tag [TABLE_DEPTH];
  int unsigned        shadow_count = 0;

  // Replies still owed by the block, oldest first.
  reply_t      awaited_replies [$];
  reply_t      observed_reply;
  reply_t      owed_reply;
  int unsigned failure_count = 0;
  int unsigned cycle_count = 0;

  // Sender bookkeeping: beats left in the current burst and beats sent so far.
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  logic [31:0] key_pool [8];

  sorted_key_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .key_i       (key_i),
    .tag_i       (tag_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .position_o  (position_o),
    .found_tag_o (found_tag_o),
    .fill_count_o(fill_count_o)
  );

  always #10 clk_i = ~clk_i;

  // Applies one request to the shadow table and returns the reply it must give.
  // Keys are compared as signed numbers; an insert goes after all equal keys,
  // while search and remove act on the first equal key from the bottom.
  function automatic reply_t shadow_apply(input logic [1:0] req, input logic signed [31:0] k,
                                          input logic [63:0] t);
    reply_t      res;
    int unsigned slot;
    int unsigned i;
    res = '0;
    case (req)
      REQ_INSERT: begin
        if (shadow_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < shadow_count && shadow_key[slot] <= k) slot++;
          for (i = shadow_count; i > slot; i--) begin
            shadow_key[i] = shadow_key[i - 1];
            shadow_tag[i] = shadow_tag[i - 1];
          end
          shadow_key[slot] = k;
          shadow_tag[slot] = t;
          shadow_count++;
          res.position = 5'(slot + 1);
        end
      end
      REQ_SEARCH, REQ_REMOVE: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          slot = 0;
          while (slot < shadow_count && shadow_key[slot] != k) slot++;
          if (slot == shadow_count) begin
            res.status = ST_MISSING;
          end else begin
            res.position = 5'(slot + 1);
            res.found_tag = shadow_tag[slot];
            if (req == REQ_REMOVE) begin
              for (i = slot; i + 1 < shadow_count; i++) begin
                shadow_key[i] = shadow_key[i + 1];
                shadow_tag[i] = shadow_tag[i + 1];
              end
              shadow_count--;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.fill_count = 5'(shadow_count);
    return res;
  endfunction

  // Picks a key for a random request. Search and remove mostly aim at keys that
  // are stored, so that hits and removals from every slot are common; the small
  // per-phase pool makes equal keys frequent, and a few keys span the full range.
  function automatic logic [31:0] pick_key(input bit aim_at_stored);
    if (aim_at_stored && shadow_count > 0 && $urandom_range(0, 3) != 0) begin
      return shadow_key[$urandom_range(0, shadow_count - 1)];
    end
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return key_pool[$urandom_range(0, 7)];
    endcase
  endfunction

  // Offers one request beat and returns at the falling edge after it is taken,
  // with valid still high. Beats go out in bursts; between bursts valid drops
  // for a random gap, though some bursts follow on with no gap at all.
  task automatic send_request(input logic [1:0] req, input logic [31:0] k, input logic [63:0] t,
                              input logic typed, input reply_t typed_reply);
    reply_t prediction;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i = 1'b1;
    req_type_i = req;
    key_i = k;
    tag_i = t;
    do @(posedge clk_i); while (!in_ready_o);
    prediction = shadow_apply(req, k, t);
    awaited_replies.push_back(typed ? typed_reply : prediction);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Holds the sender back until the block has returned every reply it owes.
  task automatic wait_for_drain();
    in_valid_i = 1'b0;
    burst_left = 0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stimulus: reset, the directed rows, then random phases that lean towards
  // filling, draining or a mix, so that the full and empty cases recur often.
  initial begin
    int unsigned row;
    int unsigned copy;
    int unsigned phase_kind;
    int unsigned phase_len;
    int unsigned n;
    int unsigned roll;
    int signed   pool_base;
    logic [1:0]  req;
    logic [31:0] k;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (row = 0; row < DIRECTED_ROWS; row++) begin
      for (copy = 0; copy < DIRECTED_STIM[row].copies; copy++) begin
        send_request(DIRECTED_STIM[row].req, DIRECTED_STIM[row].key,
                     DIRECTED_STIM[row].tag + 64'(copy), DIRECTED_STIM[row].typed,
                     DIRECTED_STIM[row].want);
      end
    end
    wait_for_drain();

    while (items_sent < ITEM_TOTAL) begin
      phase_kind = $urandom_range(0, 2);
      phase_len = $urandom_range(30, 120);
      pool_base = $urandom_range(0, 3) == 0 ? $signed($urandom) : $urandom_range(0, 40) - 20;
      foreach (key_pool[p]) key_pool[p] = pool_base + $urandom_range(0, 11);
      for (n = 0; n < phase_len && items_sent < ITEM_TOTAL; n++) begin
        roll = $urandom_range(0, 99);
        // Thresholds per phase: insert, then search, then remove; the rest no-op.
        case (phase_kind)
          0: req = roll < 70 ? REQ_INSERT : roll < 85 ? REQ_SEARCH : roll < 97 ? REQ_REMOVE
                                                                                : REQ_NOP;
          1: req = roll < 20 ? REQ_INSERT : roll < 40 ? REQ_SEARCH : roll < 97 ? REQ_REMOVE
                                                                                : REQ_NOP;
          default: req = roll < 40 ? REQ_INSERT : roll < 68 ? REQ_SEARCH
                       : roll < 96 ? REQ_REMOVE : REQ_NOP;
        endcase
        k = pick_key(req != REQ_INSERT);
        send_request(req, k, {$urandom, $urandom}, 1'b0, '0);
      end
      if ($urandom_range(0, 2) == 0) wait_for_drain();
    end
    in_valid_i = 1'b0;

    // Let the last replies arrive, then watch a little longer for stray beats.
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    if (failure_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Consumer: ready follows a pattern that switches every so often between
  // always ready, coin tosses, rare stalls and long stalls.
  initial begin
    int unsigned stall_kind;
    int unsigned run;
    @(posedge rst_ni);
    forever begin
      stall_kind = $urandom_range(0, 3);
      run = $urandom_range(20, 200);
      repeat (run) begin
        @(negedge clk_i);
        case (stall_kind)
          0: out_ready_i = 1'b1;
          1: out_ready_i = 1'($urandom_range(0, 1));
          2: out_ready_i = $urandom_range(0, 7) != 0;
          default: out_ready_i = $urandom_range(0, 15) == 0;
        endcase
      end
    end
  end

  task automatic note_failure(input string what, input reply_t want, input reply_t got);
    failure_count++;
    if (failure_count <= REPORT_LIMIT) begin
      $display("%s: expected status %0d position %0d tag %h fill %0d,",
               what, want.status, want.position, want.found_tag, want.fill_count,
               " got status %0d position %0d tag %h fill %0d",
               got.status, got.position, got.found_tag, got.fill_count);
    end
  endtask

  // Each result beat is matched against the oldest reply still owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      observed_reply = '{status_o, position_o, found_tag_o, fill_count_o};
      if (awaited_replies.size() == 0) begin
        note_failure("result beat with none owed", '0, observed_reply);
      end else begin
        owed_reply = awaited_replies.pop_front();
        if (observed_reply.status !== owed_reply.status
            || observed_reply.position !== owed_reply.position
            || observed_reply.found_tag !== owed_reply.found_tag
            || observed_reply.fill_count !== owed_reply.fill_count) begin
          note_failure("result beat mismatch", owed_reply, observed_reply);
        end
      end
    end
  end

  // A run that stalls or leaves replies owed is stopped here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
